@@ rtl/core/uart_idle_framer_frame_fifo_top_defines.svh @@
// Assertion macros shared by the checker of the idle-timeout framer.
// No dependencies; included by the checker file.
`ifndef UART_IDLE_FRAMER_FRAME_FIFO_TOP_DEFINES_SVH
`define UART_IDLE_FRAMER_FRAME_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UIFF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uiff assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define UIFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uiff assertion failed");

`endif

@@ rtl/core/uiff_pkg.sv @@
// Shared types and constants of the idle-timeout framer with frame ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package uiff_pkg;

    localparam int FRAME_SLOTS_DEF = 8;
    localparam int FRAME_BYTES_DEF = 64;

    localparam int IDLE_W           = 4;
    localparam logic [IDLE_W-1:0] IDLE_TICKS_RESET = 4'd4;
    localparam logic [IDLE_W-1:0] IDLE_MAX         = 4'd15;

    localparam int QUEUED_OUT_W = 3;
    localparam int S_TDATA_W    = 8;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 16;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    // Register map, index into the register list.
    localparam logic REG_IDLE_TICKS = 1'b0;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_TICK = 2'd1,
        MODE_SEND = 2'd2,
        MODE_DONE = 2'd3
    } mode_t;

    typedef struct packed {
        logic                    sent;
        logic [7:0]              tx_byte;
        logic                    last;
        logic [QUEUED_OUT_W-1:0] frames_queued;
        logic                    dropped;
        logic                    radio_busy_flag;
    } res_t;

endpackage

@@ rtl/core/uiff_mem.sv @@
// Frame ring storage: one write port, one registered read port.
// Depends on uiff_pkg for its default depth; no contents are reset.
`timescale 1ns / 1ps

module uiff_mem
    import uiff_pkg::*;
#(
    parameter int DEPTH = FRAME_SLOTS_DEF * FRAME_BYTES_DEF,
    parameter int AW    = $clog2(FRAME_SLOTS_DEF * FRAME_BYTES_DEF)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/uiff_cfg.sv @@
// APB register block holding the idle-tick threshold.
// Depends on uiff_pkg for the register map and widths.
`timescale 1ns / 1ps

module uiff_cfg
    import uiff_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [IDLE_W-1:0] idle_ticks
);

    logic [IDLE_W-1:0] idle_ticks_reg;
    logic [IDLE_W-1:0] idle_ticks_next;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_IDLE_TICKS);

    always_comb
    begin
        idle_ticks_next = idle_ticks_reg;
        if (psel && penable && pwrite && hit)
        begin
            idle_ticks_next = pwdata[IDLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_ticks_reg <= IDLE_TICKS_RESET;
        end
        else
        begin
            idle_ticks_reg <= idle_ticks_next;
        end
    end

    assign prdata     = hit ? {{(APB_DW-IDLE_W){1'b0}}, idle_ticks_reg} : '0;
    assign idle_ticks = idle_ticks_reg;

endmodule

@@ rtl/core/uiff_ctrl.sv @@
// Framer sequencer: staging, idle flush with padding, ring pointers and frame read-out.
// Depends on uiff_pkg; drives the ports of uiff_mem.
`timescale 1ns / 1ps

module uiff_ctrl
    import uiff_pkg::*;
#(
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int AW          = $clog2(FRAME_SLOTS_DEF * FRAME_BYTES_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDLE_W-1:0] idle_ticks,
    input  logic              in_valid,
    output logic              in_ready,
    input  mode_t             in_mode,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_res,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data
);

    localparam int SW  = $clog2(FRAME_SLOTS);
    localparam int FCW = $clog2(FRAME_BYTES);
    localparam logic [SW-1:0]  SLOT_LAST = SW'(FRAME_SLOTS - 1);
    localparam logic [FCW-1:0] BYTE_LAST = FCW'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_SEND
    } state_t;

    state_t            state_reg,  state_next;
    logic [FCW-1:0]    fill_reg,   fill_next;
    logic [IDLE_W-1:0] idle_reg,   idle_next;
    logic [SW-1:0]     wslot_reg,  wslot_next;
    logic [SW-1:0]     rslot_reg,  rslot_next;
    logic [SW-1:0]     queued_reg, queued_next;
    logic              busy_reg,   busy_next;
    logic [SW-1:0]     sslot_reg,  sslot_next;
    logic [FCW-1:0]    k_reg,      k_next;
    logic              kdone_reg,  kdone_next;
    logic              pv_reg,     pv_next;
    logic              plast_reg,  plast_next;
    logic              ov_reg,     ov_next;
    res_t              ores_reg,   ores_next;

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] slot,
                                              input logic [FCW-1:0] idx);
        addr_of = AW'(AW'(slot) * AW'(FRAME_BYTES)) + AW'(idx);
    endfunction

    function automatic logic [QUEUED_OUT_W-1:0] q_out(input logic [SW-1:0] q);
        logic [SW+QUEUED_OUT_W-1:0] qx;
        qx    = {{QUEUED_OUT_W{1'b0}}, q};
        q_out = qx[QUEUED_OUT_W-1:0];
    endfunction

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    logic              o_free;
    logic              in_fire;
    logic              advance;
    logic              full;
    logic [IDLE_W-1:0] idle_inc;

    assign o_free   = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && o_free;
    assign in_fire  = in_valid && in_ready;
    assign advance  = pv_reg && o_free;
    assign full     = (queued_reg == SLOT_LAST);
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        wslot_next  = wslot_reg;
        rslot_next  = rslot_reg;
        queued_next = queued_reg;
        busy_next   = busy_reg;
        sslot_next  = sslot_reg;
        k_next      = k_reg;
        kdone_next  = kdone_reg;
        pv_next     = pv_reg;
        plast_next  = plast_reg;
        ov_next     = ov_reg && !out_ready;
        ores_next   = ores_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_of(wslot_reg, fill_reg);
        wr_data     = 8'd0;
        rd_en       = 1'b0;
        rd_addr     = addr_of(sslot_reg, k_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ores_next.sent            = 1'b0;
                    ores_next.tx_byte         = 8'd0;
                    ores_next.last            = 1'b1;
                    ores_next.dropped         = 1'b0;
                    ov_next                   = 1'b1;
                    case (in_mode)
                        MODE_BYTE:
                        begin
                            wr_en     = 1'b1;
                            wr_data   = in_byte;
                            idle_next = '0;
                            fill_next = fill_reg + 1'b1;
                            if (fill_reg == BYTE_LAST)
                            begin
                                fill_next = '0;
                                if (full)
                                begin
                                    ores_next.dropped = 1'b1;
                                end
                                else
                                begin
                                    wslot_next  = slot_inc(wslot_reg);
                                    queued_next = queued_reg + 1'b1;
                                end
                            end
                        end
                        MODE_TICK:
                        begin
                            if (fill_reg == '0)
                            begin
                                idle_next = '0;
                            end
                            else
                            begin
                                idle_next = idle_inc;
                                if (idle_inc >= idle_ticks)
                                begin
                                    idle_next = '0;
                                    if (full)
                                    begin
                                        fill_next         = '0;
                                        ores_next.dropped = 1'b1;
                                    end
                                    else
                                    begin
                                        // The status beat waits until the tail is padded.
                                        ov_next    = ov_reg && !out_ready;
                                        state_next = ST_PAD;
                                    end
                                end
                            end
                        end
                        MODE_SEND:
                        begin
                            if (queued_reg != '0 && !busy_reg)
                            begin
                                ov_next     = ov_reg && !out_ready;
                                sslot_next  = rslot_reg;
                                rslot_next  = slot_inc(rslot_reg);
                                queued_next = queued_reg - 1'b1;
                                busy_next   = 1'b1;
                                k_next      = '0;
                                kdone_next  = 1'b0;
                                state_next  = ST_SEND;
                            end
                        end
                        MODE_DONE:
                        begin
                            busy_next = 1'b0;
                        end
                        default:
                        begin
                            busy_next = busy_reg;
                        end
                    endcase
                    ores_next.frames_queued   = q_out(queued_next);
                    ores_next.radio_busy_flag = busy_next;
                end
            end

            ST_PAD:
            begin
                wr_en = 1'b1;
                if (fill_reg != BYTE_LAST)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                else if (o_free)
                begin
                    fill_next                 = '0;
                    wslot_next                = slot_inc(wslot_reg);
                    queued_next               = queued_reg + 1'b1;
                    ov_next                   = 1'b1;
                    ores_next.sent            = 1'b0;
                    ores_next.tx_byte         = 8'd0;
                    ores_next.last            = 1'b1;
                    ores_next.dropped         = 1'b0;
                    ores_next.frames_queued   = q_out(queued_reg + 1'b1);
                    ores_next.radio_busy_flag = busy_reg;
                    state_next                = ST_IDLE;
                end
            end

            ST_SEND:
            begin
                // Read one byte ahead; a stalled output holds the read stage.
                rd_en = !kdone_reg && (!pv_reg || advance);
                if (rd_en)
                begin
                    pv_next    = 1'b1;
                    plast_next = (k_reg == BYTE_LAST);
                    k_next     = k_reg + 1'b1;
                    kdone_next = (k_reg == BYTE_LAST);
                end
                else if (advance)
                begin
                    pv_next = 1'b0;
                end
                if (advance)
                begin
                    ov_next                   = 1'b1;
                    ores_next.sent            = 1'b1;
                    ores_next.tx_byte         = rd_data;
                    ores_next.last            = plast_reg;
                    ores_next.dropped         = 1'b0;
                    ores_next.frames_queued   = q_out(queued_reg);
                    ores_next.radio_busy_flag = busy_reg;
                    if (plast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            idle_reg   <= '0;
            wslot_reg  <= '0;
            rslot_reg  <= '0;
            queued_reg <= '0;
            busy_reg   <= 1'b0;
            sslot_reg  <= '0;
            k_reg      <= '0;
            kdone_reg  <= 1'b0;
            pv_reg     <= 1'b0;
            plast_reg  <= 1'b0;
            ov_reg     <= 1'b0;
            ores_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            wslot_reg  <= wslot_next;
            rslot_reg  <= rslot_next;
            queued_reg <= queued_next;
            busy_reg   <= busy_next;
            sslot_reg  <= sslot_next;
            k_reg      <= k_next;
            kdone_reg  <= kdone_next;
            pv_reg     <= pv_next;
            plast_reg  <= plast_next;
            ov_reg     <= ov_next;
            ores_reg   <= ores_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = ores_reg;

endmodule

@@ rtl/core/uart_idle_framer_frame_fifo_top.sv @@
// A status beat is registered in the cycle after its input beat is accepted, and such
// beats can follow one a cycle while the result side keeps up and the sequencer is idle.
// An idle flush pads the frame tail in place, one byte a cycle, and raises its status
// beat with the write of the last byte, once the result side is free. A granted send
// reads the frame from the ring memory read port, one byte a cycle while the result side keeps up.
// Reset is asynchronous and resets all control state; the ring memory is not cleared.
`timescale 1ns / 1ps

module uart_idle_framer_frame_fifo_top
    import uiff_pkg::*;
#(
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] mode
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] tx_byte, [10:8] frames_queued,
                                            // [11] dropped, [12] radio_busy_flag, rest 0
    output logic                 m_tuser,   // [0] sent
    output logic                 m_tlast,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    // Every received byte is written straight into the ring slot that the write
    // pointer names, so completing a frame costs nothing but a pointer step. That
    // slot is always the one kept empty, so it never collides with a queued frame.
    localparam int DEPTH = FRAME_SLOTS * FRAME_BYTES;
    localparam int AW    = $clog2(FRAME_SLOTS * FRAME_BYTES);

    logic [IDLE_W-1:0] idle_ticks;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    res_t              res;

    uiff_cfg u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .idle_ticks (idle_ticks)
    );

    // The sequencer handles one input beat at a time; the ring is never read and
    // written in the same beat's work, so no forwarding is needed around the memory.
    uiff_ctrl #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .FRAME_BYTES (FRAME_BYTES),
        .AW          (AW)
    ) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .idle_ticks (idle_ticks),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (mode_t'(s_tuser)),
        .in_byte    (s_tdata[7:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    uiff_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result packing, lowest field first.
    assign m_tdata = {3'b000, res.radio_busy_flag, res.dropped, res.frames_queued,
                      res.tx_byte};
    assign m_tuser = res.sent;
    assign m_tlast = res.last;

endmodule

@@ rtl/core/uiff_checker.sv @@
// Port-level checks of the framer's result stream, bound to the top level.
// Depends on uiff_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "uart_idle_framer_frame_fifo_top_defines.svh"

module uiff_checker
    import uiff_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // A stalled beat must stay offered.
    `UIFF_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    // Status beats stand alone and carry no byte.
    `UIFF_ASSERT_NOW(a_status, clk, rst_n, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'd0))
    // Frame bytes are only sent with the radio marked busy and never report a drop.
    `UIFF_ASSERT_NOW(a_sendflags, clk, rst_n, m_tvalid && m_tuser, m_tdata[12] && !m_tdata[11])
    // A frame byte that is not the last is followed by another frame byte.
    `UIFF_ASSERT_NEXT(a_frame, clk, rst_n, m_tvalid && m_tready && m_tuser && !m_tlast, m_tuser)

endmodule

bind uart_idle_framer_frame_fifo_top uiff_checker u_uiff_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
